FILE: src/msb_first_bit_packer_top_defines.svh
// Assertion macros for the MSB-first bit packer.
`ifndef MSB_FIRST_BIT_PACKER_TOP_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define MBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define MBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: src/mbp_pkg.sv
// Shared types and constants of the MSB-first bit packer.
package mbp_pkg;

  localparam int unsigned PosW      = 27;
  localparam int unsigned IdxW      = 24;
  localparam int unsigned WinW      = 40;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW     = $clog2(QueueDepth);
  localparam int unsigned QCntW     = $clog2(QueueDepth + 1);

  localparam logic [IdxW-1:0] CapacityReset = '1;

  // Command codes on the input tuser
  typedef enum logic {
    CMD_PUT    = 1'b0,
    CMD_FINISH = 1'b1
  } mbp_cmd_e;

  // Register word indexes
  localparam logic REG_BYTE_CAPACITY = 1'b0;

  // One classified item waiting for the back end
  typedef struct packed {
    logic [WinW-1:0] window;     // bytes to emit, first byte in the top bits
    logic [IdxW-1:0] base_index; // stream index of the first byte
    logic [2:0]      nbytes;     // completed bytes, 0 to 4
    logic            accepted;
    logic [IdxW-1:0] byte_length;
  } mbp_entry_t;

  // One result word
  typedef struct packed {
    logic [7:0]      out_byte;
    logic            byte_valid;
    logic [IdxW-1:0] byte_index;
    logic            last;
    logic            accepted;
    logic [IdxW-1:0] byte_length;
  } mbp_result_t;

endpackage

FILE: src/msb_first_bit_packer_top.sv
// Top level of the MSB-first bit packer: stream ports, register port and assertions.
//
// Packs variable-length code words into a byte stream, MSB first. The input side takes one
// word per cycle while the four-entry queue has room; the front end settles the bit
// position, the capacity limit and the completed bytes of a word in that cycle. The back
// end emits one result word per cycle from the queue head while the output is taken, so a
// word gives max(k, 1) result words, where k is the number of bytes it completes: up to
// four for a full 32-bit put, one for a finish. byte_capacity sits at byte address 0; the
// user is to write it only while the block is idle; the block itself does not enforce
// this.
`include "msb_first_bit_packer_top_defines.svh"

module msb_first_bit_packer_top import mbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // value[31:0], bit_count[37:32], zero pad
  input  logic        s_axis_tuser,  // command
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // out_byte[7:0], byte_index[31:8], accepted[32],
                                     // byte_length[56:33], zero pad
  output logic        m_axis_tuser,  // byte_valid
  output logic        m_axis_tlast,  // last
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [IdxW-1:0] cap_q;
  logic            full, push, pop, empty;
  mbp_entry_t      entry, head;
  mbp_result_t     result;

  // Register write and read
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BYTE_CAPACITY) ? {8'h00, cap_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapacityReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BYTE_CAPACITY)) begin
      cap_q <= pwdata[IdxW-1:0];
    end
  end

  mbp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .command_i   (s_axis_tuser),
    .value_i     (s_axis_tdata[31:0]),
    .bit_count_i (s_axis_tdata[37:32]),
    .capacity_i  (cap_q),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (entry)
  );

  mbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty)
  );

  mbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result)
  );

  // Pack the output word
  assign m_axis_tdata = {7'h00, result.byte_length, result.accepted, result.byte_index,
                         result.out_byte};
  assign m_axis_tuser = result.byte_valid;
  assign m_axis_tlast = result.last;

  // A word without a byte is always the only result of its item
  `MBP_ASSERT(a_nobyte_last, m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast, "byteless word not last")
  // A word without a byte carries zero byte and index
  `MBP_ASSERT(a_nobyte_zero, m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[31:0] == 32'h0), "byteless word not zeroed")
  // A length is reported only on the closing word of a finish
  `MBP_ASSERT(a_len_last, m_axis_tvalid && (m_axis_tdata[56:33] != 24'h0) |-> m_axis_tlast && m_axis_tdata[32], "length outside finish")
  // No output word during reset
  `MBP_ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> !m_axis_tvalid, "output valid in reset")

endmodule

FILE: src/mbp_front.sv
// Front end: accepts words, appends bits to the stream state and classifies results.
module mbp_front import mbp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            command_i,
  input  logic [31:0]     value_i,
  input  logic [5:0]      bit_count_i,
  input  logic [IdxW-1:0] capacity_i,
  input  logic            full_i,
  output logic            push_o,
  output mbp_entry_t      entry_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      part_q, part_d;

  logic [PosW-1:0] cap_bits, room;
  logic [5:0]      cnt, wr_bits, total;
  logic [2:0]      offs, nbytes;
  logic [31:0]     aligned, keep_mask, new_bits;
  logic [WinW-1:0] window;
  logic [PosW:0]   len_sum;
  logic [7:0]      rest;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // Clamp the count and limit it to the room left below the capacity
  assign cnt      = (bit_count_i > 6'd32) ? 6'd32 : bit_count_i;
  assign cap_bits = {capacity_i, 3'b000};
  assign room     = (pos_q < cap_bits) ? (cap_bits - pos_q) : '0;
  assign wr_bits  = (room < {{(PosW-6){1'b0}}, cnt}) ? room[5:0] : cnt;
  assign offs     = pos_q[2:0];

  // Left-align the written bits and merge them behind the held partial byte
  assign aligned   = value_i << (6'd32 - cnt);
  assign keep_mask = ~(32'hFFFF_FFFF >> wr_bits);
  assign new_bits  = aligned & keep_mask;
  assign window    = {part_q, 32'h0} | ({new_bits, 8'h00} >> offs);
  assign total     = {3'b000, offs} + wr_bits;
  assign nbytes    = total[5:3];
  assign len_sum   = {1'b0, pos_q} + (PosW+1)'(7);

  // Pick the byte left unfinished after the completed ones
  always_comb begin
    case (nbytes)
      3'd0:    rest = window[39:32];
      3'd1:    rest = window[31:24];
      3'd2:    rest = window[23:16];
      3'd3:    rest = window[15:8];
      default: rest = window[7:0];
    endcase
  end

  // Build the queue entry and the next stream state
  always_comb begin
    entry_o.base_index = pos_q[PosW-1:3];
    if (command_i == CMD_FINISH) begin
      entry_o.window      = {part_q, 32'h0};
      entry_o.nbytes      = (offs != 3'd0) ? 3'd1 : 3'd0;
      entry_o.accepted    = 1'b1;
      entry_o.byte_length = len_sum[PosW-1:3];
      pos_d               = '0;
      part_d              = '0;
    end else begin
      entry_o.window      = window;
      entry_o.nbytes      = nbytes;
      entry_o.accepted    = (wr_bits == cnt);
      entry_o.byte_length = '0;
      pos_d               = pos_q + {{(PosW-6){1'b0}}, wr_bits};
      part_d              = rest;
    end
  end

  // Hold the bit position and partial byte between words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      part_q <= '0;
    end else if (push_o) begin
      pos_q  <= pos_d;
      part_q <= part_d;
    end
  end

endmodule

FILE: src/mbp_queue.sv
// Short queue of classified entries between the front and back ends.
module mbp_queue import mbp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  mbp_entry_t entry_i,
  output logic       full_o,
  input  logic       pop_i,
  output mbp_entry_t head_o,
  output logic       empty_o
);

  mbp_entry_t       slots_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;

  assign full_o  = (count_q == QCntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_ptr_q];

  // Store a pushed entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

endmodule

FILE: src/mbp_back.sv
// Back end: walks the bytes of each queued entry and drives the output register.
module mbp_back import mbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mbp_entry_t  head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output mbp_result_t result_o
);

  logic [1:0]  k_q, k_d;
  logic        vld_q;
  mbp_result_t res_q, res_d;
  logic        load, has_bytes, is_last;
  logic [2:0]  nres;
  logic [7:0]  sel_byte;

  assign load      = !empty_i && (!vld_q || out_ready_i);
  assign has_bytes = (head_i.nbytes != 3'd0);
  assign nres      = has_bytes ? head_i.nbytes : 3'd1;
  assign is_last   = ({1'b0, k_q} == (nres - 3'd1));
  assign pop_o     = load && is_last;
  assign k_d       = is_last ? 2'd0 : (k_q + 2'd1);

  // Select byte k of the window, first byte in the top bits
  always_comb begin
    case (k_q)
      2'd0:    sel_byte = head_i.window[39:32];
      2'd1:    sel_byte = head_i.window[31:24];
      2'd2:    sel_byte = head_i.window[23:16];
      default: sel_byte = head_i.window[15:8];
    endcase
  end

  // Form the next result word
  always_comb begin
    res_d.out_byte    = has_bytes ? sel_byte : 8'h00;
    res_d.byte_valid  = has_bytes;
    res_d.byte_index  = has_bytes ? (head_i.base_index + {{(IdxW-2){1'b0}}, k_q}) : '0;
    res_d.last        = is_last;
    res_d.accepted    = head_i.accepted;
    res_d.byte_length = head_i.byte_length;
  end

  // Hold the output word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      k_q   <= '0;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
        k_q   <= k_d;
      end else if (out_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = vld_q;
  assign result_o    = res_q;

endmodule
